// ----- design/three_class_priority_queue_top_defines.svh -----
// Assertion macros for the three-class priority queue.
// Used by the top level; the clock is clk and the synchronous reset is rst.
`ifndef THREE_CLASS_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define THREE_CLASS_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tcpq_pkg.sv -----
// Package for the three-class priority queue: sizes, codes, record types
// and the circular index helper. No dependencies.
`default_nettype none

package tcpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 32;

  localparam int IDX_W    = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W    = 5;
  localparam int PORT_H_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [1:0] CLS_RED    = 2'd0;
  localparam logic [1:0] CLS_YELLOW = 2'd1;
  localparam logic [1:0] CLS_GREEN  = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef struct packed {
    logic [1:0]             cls;
    logic [7:0]             age;
    logic [HANDLE_BITS-1:0] name;
    logic [HANDLE_BITS-1:0] text;
  } entry_t;

  typedef struct packed {
    logic   act;
    entry_t rec;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    entry_t           rec;
    logic [OCC_W-1:0] occ;
  } result_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DQ,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_RESULT
  } state_t;

  // Physical slot of a logical position, counted from the head, wrapping
  // around the ring of QUEUE_DEPTH slots.
  function automatic idx_t wrap_add(input idx_t base, input cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return IDX_W'(sum);
  endfunction

endpackage

`default_nettype wire

// ----- design/three_class_priority_queue_top.sv -----
// Top level of the three-class priority queue: ports, output register and
// checks. Depends on tcpq_pkg, tcpq_seq, tcpq_store and the defines header.
//
//   Channel  Handshake            Payload
//   -------  -------------------  ---------------------------------------------
//   in       in_valid / in_ready  action, urgency, patient_age, name_handle,
//                                 text_handle
//   out      out_valid/out_ready  status, out_urgency, out_age, out_name,
//                                 out_text, occupancy
//
// Every item gives exactly one result item. After an item is accepted the
// block is busy until its result is loaded into the output register.
// Each item passes through S_EXEC and then S_RESULT; a dequeue of a held
// record also passes S_DQ, and a yellow enqueue with green records held
// first moves each green record up one slot (S_SH_RD, then S_SH_WR) and
// then writes the new record in S_INS. Those moves go one slot per read and
// write pair through the single record store, which has one write port. The
// block returns to S_IDLE before the next item can be accepted.
// rst (synchronous, active high) empties the queue; no clearing pass runs.
// A result waiting in the output register does not stop the next item from
// being accepted; only the load of its own result waits for a free register.
`default_nettype none
`include "three_class_priority_queue_top_defines.svh"

module three_class_priority_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [1:0]  urgency,
  input  logic [7:0]  patient_age,
  input  logic [31:0] name_handle,
  input  logic [31:0] text_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [1:0]  out_urgency,
  output logic [7:0]  out_age,
  output logic [31:0] out_name,
  output logic [31:0] out_text,
  output logic [4:0]  occupancy
);
  import tcpq_pkg::*;

  item_t    in_item;
  result_t  res;
  result_t  out_reg;
  logic     res_push;
  logic     res_free;
  mem_req_t mem_req;
  entry_t   rdata;

  // Handles keep their low HANDLE_BITS bits only.
  assign in_item.act      = action;
  assign in_item.rec.cls  = urgency;
  assign in_item.rec.age  = patient_age;
  assign in_item.rec.name = name_handle[HANDLE_BITS-1:0];
  assign in_item.rec.text = text_handle[HANDLE_BITS-1:0];

  tcpq_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item     (in_item),
    .res_free (res_free),
    .res_push (res_push),
    .res      (res),
    .mem_req  (mem_req),
    .rdata    (rdata)
  );

  tcpq_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // The output register is free when it is empty or being taken this cycle.
  assign res_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_reg <= res;
    end
  end

  assign status      = out_reg.status;
  assign out_urgency = out_reg.rec.cls;
  assign out_age     = out_reg.rec.age;
  assign out_name    = PORT_H_W'(out_reg.rec.name);
  assign out_text    = PORT_H_W'(out_reg.rec.text);
  assign occupancy   = out_reg.occ;

  `TCPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `TCPQ_ASSERT_NOW(a_full_occ, out_valid && status == STAT_FULL, occupancy == OCC_W'(QUEUE_DEPTH), "full status below depth")
  `TCPQ_ASSERT_NOW(a_empty_occ, out_valid && status == STAT_EMPTY, occupancy == '0 && out_urgency == CLS_RED, "empty status with records")
  `TCPQ_ASSERT_NOW(a_class_range, out_valid && status == STAT_DONE, out_urgency != 2'd3, "dequeued class out of range")

endmodule

`default_nettype wire

// ----- design/tcpq_store.sv -----
// Record storage ring: one write port and one registered read port.
// Depends on tcpq_pkg.
`default_nettype none

module tcpq_store (
  input  logic              clk,
  input  tcpq_pkg::mem_req_t req,
  output tcpq_pkg::entry_t   rdata
);
  import tcpq_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ----- design/tcpq_seq.sv -----
// Sequencer for the priority queue: ring pointers, counts and the slot mover
// that opens a hole ahead of the green records. Depends on tcpq_pkg.
`default_nettype none

module tcpq_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcpq_pkg::item_t    item,
  input  logic               res_free,
  output logic               res_push,
  output tcpq_pkg::result_t  res,
  output tcpq_pkg::mem_req_t mem_req,
  input  tcpq_pkg::entry_t   rdata
);
  import tcpq_pkg::*;

  state_t     state, state_next;
  idx_t       head, head_next;
  cnt_t       fill, fill_next;
  cnt_t       greens, greens_next;
  cnt_t       cnt, cnt_next;
  item_t      cur, cur_next;
  logic [1:0] res_status, res_status_next;
  entry_t     res_rec, res_rec_next;
  cnt_t       pos;
  idx_t       head_dec;

  // The queue stays sorted by class, so the first green sits right after
  // the red and yellow records.
  assign pos      = fill - greens;
  assign head_dec = (head == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head - 1'b1;

  assign res.status = res_status;
  assign res.rec    = res_rec;
  assign res.occ    = OCC_W'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      fill   <= '0;
      greens <= '0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      fill   <= fill_next;
      greens <= greens_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    cur        <= cur_next;
    res_status <= res_status_next;
    res_rec    <= res_rec_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    fill_next       = fill;
    greens_next     = greens;
    cnt_next        = cnt;
    cur_next        = cur;
    res_status_next = res_status;
    res_rec_next    = res_rec;
    in_ready        = 1'b0;
    res_push        = 1'b0;
    mem_req.we      = 1'b0;
    mem_req.waddr   = head;
    mem_req.wdata   = cur.rec;
    mem_req.raddr   = head;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_next = item;
          if (item.rec.cls > CLS_GREEN) begin
            cur_next.rec.cls = CLS_GREEN;
          end
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_next = STAT_DONE;
        res_rec_next    = '0;
        state_next      = S_RESULT;
        if (cur.act == ACT_ENQ) begin
          if (fill == CNT_W'(QUEUE_DEPTH)) begin
            res_status_next = STAT_FULL;
          end else if (cur.rec.cls == CLS_RED) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = head_dec;
            head_next     = head_dec;
            fill_next     = fill + 1'b1;
          end else if (cur.rec.cls == CLS_GREEN || greens == '0) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wrap_add(head, fill);
            fill_next     = fill + 1'b1;
            if (cur.rec.cls == CLS_GREEN) begin
              greens_next = greens + 1'b1;
            end
          end else begin
            cnt_next   = fill;
            state_next = S_SH_RD;
          end
        end else begin
          if (fill == '0) begin
            res_status_next = STAT_EMPTY;
          end else begin
            state_next = S_DQ;
          end
        end
      end
      S_DQ: begin
        res_rec_next = rdata;
        head_next    = wrap_add(head, CNT_W'(1));
        fill_next    = fill - 1'b1;
        if (rdata.cls == CLS_GREEN) begin
          greens_next = greens - 1'b1;
        end
        state_next = S_RESULT;
      end
      S_SH_RD: begin
        mem_req.raddr = wrap_add(head, cnt - 1'b1);
        state_next    = S_SH_WR;
      end
      S_SH_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wrap_add(head, cnt);
        mem_req.wdata = rdata;
        cnt_next      = cnt - 1'b1;
        state_next    = ((cnt - 1'b1) == pos) ? S_INS : S_SH_RD;
      end
      S_INS: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wrap_add(head, pos);
        fill_next     = fill + 1'b1;
        state_next    = S_RESULT;
      end
      S_RESULT: begin
        if (res_free) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
